>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the line rasterizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define BLR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("line rasterizer assertion failed");

// Consequent in the cycle after the antecedent.
`define BLR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("line rasterizer assertion failed");

`endif

>>> rtl/core/blr_pkg.sv
// Package of the line rasterizer: codes, widths and reset values.
`default_nettype none

package blr_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int RASTER_BITS    = 11;
	localparam int COLOUR_BITS    = 8;

	localparam logic [RASTER_BITS-1:0] RASTER_RESET = 11'd512;

	typedef enum logic {
		ACT_START   = 1'b0,
		ACT_ADVANCE = 1'b1
	} action_t;

	typedef enum logic {
		CFG_RASTER_WIDTH  = 1'b0,
		CFG_RASTER_HEIGHT = 1'b1
	} cfg_index_t;

endpackage

`default_nettype wire

>>> rtl/core/bresenham_line_rasterizer.sv
// Top level of the Bresenham line rasterizer: input register, line state and result register.
//
//  channel  side    handshake              content
//  s_*      slave   s_tvalid / s_tready    start or advance words, action in s_tuser
//  m_*      master  m_tvalid / m_tready    pixel words, inside flag in m_tuser, last in m_tlast
//  cfg_*    slave   cfg_valid / cfg_ready  raster width and height writes
//
// A word waits in the input register until processed, and an advance word of an active line
// then loads its pixel into the result register; one word is taken per cycle unless stalled.
// The pixel step is a sign test, a subtract and an add on the error term and increments of the coordinates.
// Reset clears the line state to idle and sets both raster sizes to 512.
// A stalled pixel word holds the result register, which then holds the input register.
// Configuration writes are always taken and need no stall.
`default_nettype none

module bresenham_line_rasterizer #(
	parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	// start_x, start_y, end_x, end_y, red_in, green_in, blue_in, zero fill
	input  wire logic [((4*COORD_BITS+3*blr_pkg::COLOUR_BITS+7)/8)*8-1:0] s_tdata,
	// action
	input  wire logic                                 s_tuser,
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	// pixel_x, pixel_y, red_out, green_out, blue_out, zero fill
	output logic [((2*COORD_BITS+3*blr_pkg::COLOUR_BITS+7)/8)*8-1:0] m_tdata,
	// inside_raster
	output logic                                      m_tuser,
	output logic                                      m_tlast,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic                                 cfg_index,
	input  wire logic [blr_pkg::RASTER_BITS-1:0]      cfg_data
);

	localparam int CB    = COORD_BITS;
	localparam int CW    = blr_pkg::COLOUR_BITS;
	localparam int RB    = blr_pkg::RASTER_BITS;
	localparam int ERRW  = CB + 3;
	localparam int IN_W  = ((4*CB+3*CW+7)/8)*8;
	localparam int OUT_W = ((2*CB+3*CW+7)/8)*8;
	localparam int CMPW  = (CB > RB) ? CB : RB;

	logic [RB-1:0] raster_width_q;
	logic [RB-1:0] raster_height_q;

	logic            valid_s1;
	logic [IN_W-1:0] data_s1;
	logic            action_s1;
	logic            fire;
	logic            out_free;

	logic [CB-1:0]   cur_x_q;
	logic [CB-1:0]   cur_y_q;
	logic [ERRW-1:0] err_q;
	logic [CB:0]     maj2_q;
	logic [CB:0]     min2_q;
	logic            sx_neg_q;
	logic            sy_neg_q;
	logic            x_major_q;
	logic [CB:0]     pixels_left_q;
	logic [3*CW-1:0] colour_q;
	logic            active_q;

	logic [CB-1:0]   x0;
	logic [CB-1:0]   y0;
	logic [CB-1:0]   x1;
	logic [CB-1:0]   y1;
	logic [CB:0]     dx;
	logic [CB:0]     dy;
	logic [CB:0]     ndx;
	logic [CB:0]     ndy;
	logic [CB-1:0]   adx;
	logic [CB-1:0]   ady;
	logic            x_major_new;
	logic [CB-1:0]   maj;
	logic [CB-1:0]   mnr;
	logic [ERRW-1:0] err_init;

	logic            err_ge;
	logic [ERRW-1:0] err_adj;
	logic [ERRW-1:0] err_next;
	logic            step_x;
	logic            step_y;
	logic [CB-1:0]   inc_x;
	logic [CB-1:0]   inc_y;
	logic [CB-1:0]   next_x;
	logic [CB-1:0]   next_y;
	logic            last;
	logic            in_raster;
	logic            emit;

	logic [OUT_W-1:0] m_tdata_q;
	logic             m_tvalid_q;
	logic             m_tuser_q;
	logic             m_tlast_q;
	logic [OUT_W-1:0] pixel_word;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raster_width_q  <= blr_pkg::RASTER_RESET;
			raster_height_q <= blr_pkg::RASTER_RESET;
		end else if (cfg_valid) begin
			unique case (blr_pkg::cfg_index_t'(cfg_index))
				blr_pkg::CFG_RASTER_WIDTH:  raster_width_q  <= cfg_data;
				blr_pkg::CFG_RASTER_HEIGHT: raster_height_q <= cfg_data;
			endcase
		end
	end

	assign out_free = !m_tvalid_q || m_tready;
	assign fire     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1   <= s_tdata;
			action_s1 <= s_tuser;
		end
	end

	// Line set-up from the endpoints of a start word.
	always_comb begin
		x0  = data_s1[0*CB +: CB];
		y0  = data_s1[1*CB +: CB];
		x1  = data_s1[2*CB +: CB];
		y1  = data_s1[3*CB +: CB];
		dx  = {x1[CB-1], x1} - {x0[CB-1], x0};
		dy  = {y1[CB-1], y1} - {y0[CB-1], y0};
		ndx = -dx;
		ndy = -dy;
		adx = dx[CB] ? ndx[CB-1:0] : dx[CB-1:0];
		ady = dy[CB] ? ndy[CB-1:0] : dy[CB-1:0];
		x_major_new = adx > ady;
		maj = x_major_new ? adx : ady;
		mnr = x_major_new ? ady : adx;
		err_init = {2'b00, mnr, 1'b0} - {3'b000, maj};
	end

	// One pixel step of the running line.
	always_comb begin
		err_ge   = !err_q[ERRW-1];
		err_adj  = err_ge ? (err_q - {2'b00, maj2_q}) : err_q;
		err_next = err_adj + {2'b00, min2_q};
		step_x   = x_major_q || err_ge;
		step_y   = !x_major_q || err_ge;
		inc_x    = sx_neg_q ? {CB{1'b1}} : {{(CB-1){1'b0}}, 1'b1};
		inc_y    = sy_neg_q ? {CB{1'b1}} : {{(CB-1){1'b0}}, 1'b1};
		next_x   = step_x ? (cur_x_q + inc_x) : cur_x_q;
		next_y   = step_y ? (cur_y_q + inc_y) : cur_y_q;
		last     = (pixels_left_q[CB:1] == '0);
		in_raster = !cur_x_q[CB-1] && !cur_y_q[CB-1]
			&& (CMPW'(cur_x_q) < CMPW'(raster_width_q))
			&& (CMPW'(cur_y_q) < CMPW'(raster_height_q));
		emit     = fire && (blr_pkg::action_t'(action_s1) == blr_pkg::ACT_ADVANCE) && active_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q       <= '0;
			cur_y_q       <= '0;
			err_q         <= '0;
			maj2_q        <= '0;
			min2_q        <= '0;
			sx_neg_q      <= 1'b0;
			sy_neg_q      <= 1'b0;
			x_major_q     <= 1'b0;
			pixels_left_q <= '0;
			colour_q      <= '0;
			active_q      <= 1'b0;
		end else if (fire) begin
			unique case (blr_pkg::action_t'(action_s1))
				blr_pkg::ACT_START: begin
					cur_x_q       <= x0;
					cur_y_q       <= y0;
					err_q         <= err_init;
					maj2_q        <= {maj, 1'b0};
					min2_q        <= {mnr, 1'b0};
					sx_neg_q      <= dx[CB];
					sy_neg_q      <= dy[CB];
					x_major_q     <= x_major_new;
					pixels_left_q <= {1'b0, maj} + {{CB{1'b0}}, 1'b1};
					colour_q      <= {data_s1[4*CB +: CW], data_s1[4*CB+CW +: CW],
						data_s1[4*CB+2*CW +: CW]};
					active_q      <= 1'b1;
				end
				blr_pkg::ACT_ADVANCE: begin
					if (active_q) begin
						cur_x_q       <= next_x;
						cur_y_q       <= next_y;
						err_q         <= err_next;
						pixels_left_q <= last ? '0 : (pixels_left_q - {{CB{1'b0}}, 1'b1});
						active_q      <= !last;
					end
				end
			endcase
		end
	end

	always_comb begin
		pixel_word = '0;
		pixel_word[0*CB +: CB]         = cur_x_q;
		pixel_word[1*CB +: CB]         = cur_y_q;
		pixel_word[2*CB +: CW]         = colour_q[2*CW +: CW];
		pixel_word[2*CB+CW +: CW]      = colour_q[CW +: CW];
		pixel_word[2*CB+2*CW +: CW]    = colour_q[0 +: CW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_tdata_q <= pixel_word;
			m_tuser_q <= in_raster;
			m_tlast_q <= last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

`default_nettype wire

>>> rtl/core/blr_checker.sv
// Port-level checker of the line rasterizer and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module blr_checker #(
	parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF
) (
	input wire logic                                 clk,
	input wire logic                                 arst_n,
	input wire logic                                 s_tvalid,
	input wire logic                                 s_tready,
	input wire logic [((4*COORD_BITS+3*blr_pkg::COLOUR_BITS+7)/8)*8-1:0] s_tdata,
	input wire logic                                 s_tuser,
	input wire logic                                 m_tvalid,
	input wire logic                                 m_tready,
	input wire logic [((2*COORD_BITS+3*blr_pkg::COLOUR_BITS+7)/8)*8-1:0] m_tdata,
	input wire logic                                 m_tuser,
	input wire logic                                 m_tlast,
	input wire logic                                 cfg_valid,
	input wire logic                                 cfg_ready,
	input wire logic                                 cfg_index,
	input wire logic [blr_pkg::RASTER_BITS-1:0]      cfg_data
);

	logic m_stall;
	logic s_take;

	assign m_stall = m_tvalid && !m_tready;
	assign s_take  = s_tvalid && s_tready;

	// A stalled pixel word keeps its contents.
	`BLR_ASSERT_NEXT(a_out_hold, clk, arst_n, m_stall, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

	// A word taken while the output stalls fills the input register, so a further stall blocks input.
	`BLR_ASSERT_NEXT(a_back_pressure, clk, arst_n, m_stall && s_take, m_tready || !s_tready)

	// A fresh pixel word follows an input word that was taken and passed through the input register.
	`BLR_ASSERT_NOW(a_out_cause, clk, arst_n, $rose(m_tvalid), $past(s_take, 2))

	// The configuration channel never stalls.
	`BLR_ASSERT_NOW(a_cfg_ready, clk, arst_n, cfg_valid, cfg_ready)

endmodule

bind bresenham_line_rasterizer blr_checker #(.COORD_BITS(COORD_BITS)) u_blr_checker (.*);

`default_nettype wire

>>> test/tb.sv
// Self-checking testbench for the Bresenham line rasterizer, with its own line model.
module tb;
	import blr_pkg::*;

	localparam int CB   = COORD_BITS_DEF;
	localparam int CMIN = -(2 ** (CB - 1));
	localparam int CMAX = 2 ** (CB - 1) - 1;
	localparam int SDW  = ((4 * CB + 3 * COLOUR_BITS + 7) / 8) * 8;
	localparam int MDW  = ((2 * CB + 3 * COLOUR_BITS + 7) / 8) * 8;

	typedef struct {
		action_t                act;
		logic signed [CB-1:0]   x0, y0, x1, y1;
		logic [COLOUR_BITS-1:0] r, g, b;
	} line_item_t;

	typedef struct packed {
		logic [CB-1:0]          x, y;
		logic [COLOUR_BITS-1:0] r, g, b;
		logic                   in_raster, last;
	} pixel_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [SDW-1:0]         s_tdata = '0;
	logic                   s_tuser = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [MDW-1:0]         m_tdata;
	logic                   m_tuser;
	logic                   m_tlast;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic                   cfg_index = CFG_RASTER_WIDTH;
	logic [RASTER_BITS-1:0] cfg_data = '0;

	bresenham_line_rasterizer dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// Line model state.
	logic [RASTER_BITS-1:0] raster_cols = RASTER_RESET;
	logic [RASTER_BITS-1:0] raster_rows = RASTER_RESET;
	logic signed [CB-1:0]   cur_x = '0, cur_y = '0;
	int                     err_acc = 0, major_twice = 0, minor_twice = 0;
	bit                     x_back = 0, y_back = 0, x_major = 0, drawing = 0;
	int                     pixels_left = 0;
	logic [23:0]            line_rgb = '0;

	line_item_t stimulus_q[$];
	pixel_t     pixel_q[$];
	line_item_t drv_item;
	pixel_t     got, want;
	bit         s_fire = 0;
	int         s_gap = 0, m_stall = 0, calm_cnt = 0;
	bit         calm = 0;
	int         mismatches = 0, lines_started = 0, pixels_seen = 0;
	int         pixels_inside = 0, lines_ended = 0, settings_run = 1;

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic string fmt_pixel(pixel_t p);
		return $sformatf("x=%0d y=%0d rgb=%02x%02x%02x inside=%0b last=%0b",
			$signed(p.x), $signed(p.y), p.r, p.g, p.b, p.in_raster, p.last);
	endfunction

	task automatic trace_step(input line_item_t it);
		int dx, dy, major, minor;
		pixel_t px;
		if (it.act == ACT_START) begin
			dx = int'(it.x1) - int'(it.x0);
			dy = int'(it.y1) - int'(it.y0);
			x_back = dx < 0;
			y_back = dy < 0;
			if (dx < 0) dx = -dx;
			if (dy < 0) dy = -dy;
			x_major = dx > dy;
			major = x_major ? dx : dy;
			minor = x_major ? dy : dx;
			major_twice = 2 * major;
			minor_twice = 2 * minor;
			err_acc = 2 * minor - major;
			cur_x = it.x0;
			cur_y = it.y0;
			pixels_left = major + 1;
			line_rgb = {it.r, it.g, it.b};
			drawing = 1;
			lines_started++;
		end else if (drawing) begin
			px.x = cur_x;
			px.y = cur_y;
			{px.r, px.g, px.b} = line_rgb;
			px.in_raster = cur_x >= 0 && cur_y >= 0 && int'(cur_x) < int'(raster_cols)
				&& int'(cur_y) < int'(raster_rows);
			px.last = pixels_left <= 1;
			pixel_q.push_back(px);
			if (err_acc >= 0) begin
				err_acc -= major_twice;
				if (x_major)
					cur_y = CB'(cur_y + (y_back ? -1 : 1));
				else
					cur_x = CB'(cur_x + (x_back ? -1 : 1));
			end
			err_acc += minor_twice;
			if (x_major)
				cur_x = CB'(cur_x + (x_back ? -1 : 1));
			else
				cur_y = CB'(cur_y + (y_back ? -1 : 1));
			if (px.last) begin
				pixels_left = 0;
				drawing = 0;
			end else begin
				pixels_left--;
			end
		end
	endtask

	always @(negedge clk) begin
		if (calm_cnt == 0) begin
			calm <= $urandom_range(0, 3) == 0;
			calm_cnt <= $urandom_range(20, 150);
		end else begin
			calm_cnt <= calm_cnt - 1;
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_fire) begin
			if (s_gap > 0) begin
				s_gap <= s_gap - 1;
				s_tvalid <= 1'b0;
			end else if (stimulus_q.size() > 0) begin
				drv_item = stimulus_q.pop_front();
				s_tdata <= {drv_item.b, drv_item.g, drv_item.r,
					drv_item.y1, drv_item.x1, drv_item.y0, drv_item.x0};
				s_tuser <= drv_item.act;
				s_tvalid <= 1'b1;
				s_gap <= gap_len();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (m_stall > 0) begin
			m_stall <= m_stall - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			m_stall <= gap_len();
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			s_fire <= 1'b0;
		end else begin
			s_fire <= s_tvalid && s_tready;
			if (s_tvalid && s_tready)
				trace_step(drv_item);
			if (m_tvalid && m_tready) begin
				got.x = m_tdata[CB-1:0];
				got.y = m_tdata[2*CB-1:CB];
				got.r = m_tdata[2*CB+7:2*CB];
				got.g = m_tdata[2*CB+15:2*CB+8];
				got.b = m_tdata[2*CB+23:2*CB+16];
				got.in_raster = m_tuser;
				got.last = m_tlast;
				pixels_seen++;
				if (got.in_raster) pixels_inside++;
				if (got.last) lines_ended++;
				if (pixel_q.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected pixel: %s", fmt_pixel(got));
					mismatches++;
				end else begin
					want = pixel_q.pop_front();
					if (got.x !== want.x || got.y !== want.y || got.r !== want.r
						|| got.g !== want.g || got.b !== want.b
						|| got.in_raster !== want.in_raster || got.last !== want.last) begin
						if (mismatches < 10)
							$display("pixel mismatch: expected %s, got %s",
								fmt_pixel(want), fmt_pixel(got));
						mismatches++;
					end
				end
			end
		end
	end

	task automatic push_start(input int x0, y0, x1, y1, input logic [23:0] rgb);
		line_item_t it;
		it.act = ACT_START;
		it.x0 = CB'(x0);
		it.y0 = CB'(y0);
		it.x1 = CB'(x1);
		it.y1 = CB'(y1);
		{it.r, it.g, it.b} = rgb;
		stimulus_q.push_back(it);
	endtask

	// Advance words carry random data, which the block must ignore.
	task automatic push_advances(input int n);
		line_item_t it;
		repeat (n) begin
			it.act = ACT_ADVANCE;
			it.x0 = CB'($urandom);
			it.y0 = CB'($urandom);
			it.x1 = CB'($urandom);
			it.y1 = CB'($urandom);
			{it.r, it.g, it.b} = 24'($urandom);
			stimulus_q.push_back(it);
		end
	endtask

	function automatic int pick_anchor(input int size);
		int v;
		case ($urandom_range(0, 3))
			0, 1: v = int'($urandom_range(0, 2 ** CB - 1)) + CMIN;
			2: v = int'($urandom_range(0, size + 16)) - 8;
			default: v = ($urandom_range(0, 1) ? size : 0) + int'($urandom_range(0, 6)) - 3;
		endcase
		return v > CMAX ? CMAX : v;
	endfunction

	// Mostly complete lines with random content; some are cut short, overrun or stray.
	task automatic add_random_lines(input int budget);
		int n, len, other, dx, dy, x0, y0, x1, y1, nadv, r;
		n = 0;
		while (n < budget) begin
			r = $urandom_range(0, 99);
			if (r < 4) begin
				push_advances(1);
				continue;
			end
			if (r < 85)
				len = $urandom_range(0, 24);
			else if (r < 98)
				len = $urandom_range(25, 150);
			else
				len = $urandom_range(151, 500);
			other = ($urandom_range(0, 9) == 0) ? len : $urandom_range(0, len);
			if ($urandom_range(0, 1)) begin
				dx = len;
				dy = other;
			end else begin
				dx = other;
				dy = len;
			end
			if ($urandom_range(0, 1)) dx = -dx;
			if ($urandom_range(0, 1)) dy = -dy;
			x0 = pick_anchor(int'(raster_cols));
			y0 = pick_anchor(int'(raster_rows));
			x1 = x0 + dx;
			if (x1 > CMAX || x1 < CMIN) x1 = x0 - dx;
			y1 = y0 + dy;
			if (y1 > CMAX || y1 < CMIN) y1 = y0 - dy;
			r = $urandom_range(0, 99);
			if (r < 75)
				nadv = len + 1;
			else if (r < 85)
				nadv = $urandom_range(0, len);
			else if (r < 95)
				nadv = len + 1 + $urandom_range(1, 3);
			else
				nadv = 0;
			push_start(x0, y0, x1, y1, 24'($urandom));
			push_advances(nadv);
			n += 1 + ((nadv < len + 1) ? nadv : len + 1);
		end
	endtask

	task automatic write_reg(input cfg_index_t idx, input int val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[RASTER_BITS-1:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == CFG_RASTER_WIDTH)
			raster_cols = val[RASTER_BITS-1:0];
		else
			raster_rows = val[RASTER_BITS-1:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Starts give no pixel, so the task goes on waiting after the last one.
	task automatic wait_idle();
		while (stimulus_q.size() != 0 || s_tvalid || pixel_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int cols[6] = '{2047, 1, 0, 2047, 0, 20};
		int rows[6] = '{2047, 1, 2047, 0, 0, 700};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		push_advances(1);
		push_start(5, 5, 5, 5, 24'hffffff);
		push_advances(2);
		push_start(CMIN, CMIN, CMAX, CMAX, 24'h000000);
		push_advances(2);
		push_start(CMAX, CMAX, CMAX - 3, CMAX - 1, 24'hff0080);
		push_advances(4);
		push_start(0, 0, 3, -3, 24'h010203);
		push_advances(4);
		push_start(-2, -1, 1, 0, 24'h7f807f);
		push_advances(4);
		add_random_lines(210);
		wait_idle();

		for (int k = 0; k < 6; k++) begin
			if (k == 4) begin
				cols[k] = $urandom_range(1, 2047);
				rows[k] = $urandom_range(1, 2047);
			end
			write_reg(CFG_RASTER_WIDTH, cols[k]);
			write_reg(CFG_RASTER_HEIGHT, rows[k]);
			add_random_lines(230);
			wait_idle();
			settings_run++;
		end
		repeat (8) @(posedge clk);

		$display("Drew %0d lines over %0d raster sizes, including zero and full-size rasters.",
			lines_started, settings_run);
		$display("Checked %0d pixels: %0d inside the raster, %0d line ends, %0d mismatches.",
			pixels_seen, pixels_inside, lines_ended, mismatches);
		if (mismatches == 0 && pixel_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#8000000;
		$display("simulation failed");
		$finish;
	end
endmodule
